### hdl/icdp_pkg.sv
// Shared types and constants for the integer complexity table engine.
`timescale 1ns / 1ps

package icdp_pkg;

    localparam int TARGET_W = 16;
    localparam int COUNT_W  = 6;
    localparam int OUT_W    = 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SPLIT,
        ST_FACT_TEST,
        ST_DIV,
        ST_FACT_READ,
        ST_WRITE,
        ST_LOOKUP,
        ST_LOOKUP_WAIT,
        ST_RESULT
    } state_t;

endpackage

### hdl/integer_complexity_dp.sv
// Integer complexity engine: lazily filled cost table with split and factor search.
//
//  channel | signals                          | beat
//  s       | s_tvalid s_tready s_tdata        | target_number
//  m       | m_tvalid m_tready m_tdata m_tuser | ones_count, out_of_range
//
// Filling entry i runs the split loop (one two-port table read per cycle), then the
// factor search with the serial divider (IW steps) per candidate factor; a hit on a
// filled entry is read through ST_LOOKUP and ST_LOOKUP_WAIT. Reset clears control
// and the fill count. s_tready is high only while idle; a finished result waits in
// the output register while the next beat is taken, and the engine holds in ST_RESULT
// until that register frees.
`timescale 1ns / 1ps

module integer_complexity_dp #(
    parameter int MAX_N = 4096
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [15:0] s_tdata,   // [15:0] target_number
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [5:0] ones_count, [7:6] zero
    output logic       m_tuser     // [0] out_of_range
);

    import icdp_pkg::*;

    localparam int IW    = $clog2(MAX_N + 1);
    localparam int SQW   = IW + 2;
    localparam int CW    = $clog2(IW);
    localparam int DEPTH = MAX_N + 1;

    localparam logic [TARGET_W-1:0] MAX_T   = TARGET_W'(MAX_N);
    localparam logic [CW-1:0]       DIV_END = CW'(IW - 1);

    logic [COUNT_W-1:0] mem [DEPTH];

    state_t state_reg, state_next;

    logic [IW-1:0]      n_reg, n_next;
    logic [IW:0]        fill_reg, fill_next;
    logic [IW-1:0]      j_reg, j_next;
    logic [SQW-1:0]     jsq_reg, jsq_next;
    logic [COUNT_W-1:0] min_reg, min_next;
    logic               pend_reg, pend_next;
    logic [IW-1:0]      rem_reg, rem_next;
    logic [IW-1:0]      quo_reg, quo_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [COUNT_W-1:0] res_count_reg, res_count_next;
    logic               res_oor_reg, res_oor_next;
    logic               out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;
    logic               out_oor_reg, out_oor_next;

    logic [COUNT_W-1:0] rd_a_reg, rd_b_reg;
    logic [IW-1:0]      rd_a_addr, rd_b_addr, wr_addr;
    logic [COUNT_W-1:0] wr_data;
    logic               wr_en;

    logic [IW-1:0]      cur_i;
    logic               filled_enough;
    logic               out_free;
    logic               in_range;
    logic [COUNT_W:0]   pair_sum;
    logic [COUNT_W-1:0] pair_sat;
    logic [IW:0]        rem_sh;
    logic [IW:0]        rem_sub;

    assign cur_i         = fill_reg[IW-1:0];
    assign filled_enough = fill_reg > {1'b0, n_reg};
    assign out_free      = !out_valid_reg || m_tready;
    assign in_range      = s_tdata <= MAX_T;
    assign pair_sum      = {1'b0, rd_a_reg} + {1'b0, rd_b_reg};
    assign pair_sat      = (pair_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : pair_sum[COUNT_W-1:0];
    assign rem_sh        = {rem_reg, quo_reg[IW-1]};
    assign rem_sub       = rem_sh - {1'b0, j_reg};

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_W - COUNT_W)'(0), out_count_reg};
    assign m_tuser  = out_oor_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem[rd_a_addr];
        rd_b_reg <= mem[rd_b_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = in_range ? ST_CHECK : ST_RESULT;
                end
            end
            ST_CHECK:
            begin
                if (filled_enough)
                begin
                    state_next = ST_LOOKUP;
                end
                else if (fill_reg > (IW + 1)'(3))
                begin
                    state_next = ST_SPLIT;
                end
            end
            ST_SPLIT:
            begin
                if (j_reg > (cur_i >> 1))
                begin
                    state_next = ST_FACT_TEST;
                end
            end
            ST_FACT_TEST:
            begin
                state_next = (jsq_reg <= SQW'(cur_i)) ? ST_DIV : ST_WRITE;
            end
            ST_DIV:
            begin
                if (cnt_reg == DIV_END)
                begin
                    state_next = ST_FACT_READ;
                end
            end
            ST_FACT_READ:   state_next = ST_FACT_TEST;
            ST_WRITE:       state_next = ST_CHECK;
            ST_LOOKUP:      state_next = ST_LOOKUP_WAIT;
            ST_LOOKUP_WAIT: state_next = ST_RESULT;
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:        state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        n_next         = n_reg;
        fill_next      = fill_reg;
        j_next         = j_reg;
        jsq_next       = jsq_reg;
        min_next       = (pend_reg && (pair_sat < min_reg)) ? pair_sat : min_reg;
        pend_next      = 1'b0;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        res_count_next = res_count_reg;
        res_oor_next   = res_oor_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_count_next = out_count_reg;
        out_oor_next   = out_oor_reg;
        rd_a_addr      = j_reg;
        rd_b_addr      = cur_i - j_reg;
        wr_en          = 1'b0;
        wr_addr        = cur_i;
        wr_data        = min_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    n_next         = s_tdata[IW-1:0];
                    res_count_next = '0;
                    res_oor_next   = !in_range;
                end
            end
            ST_CHECK:
            begin
                if (!filled_enough)
                begin
                    if (fill_reg <= (IW + 1)'(3))
                    begin
                        wr_en     = 1'b1;
                        wr_data   = COUNT_W'(cur_i);
                        fill_next = fill_reg + 1'b1;
                    end
                    else
                    begin
                        j_next   = IW'(1);
                        min_next = COUNT_MAX;
                    end
                end
            end
            ST_SPLIT:
            begin
                if (j_reg <= (cur_i >> 1))
                begin
                    pend_next = 1'b1;
                    j_next    = j_reg + 1'b1;
                end
                else
                begin
                    j_next   = IW'(2);
                    jsq_next = SQW'(4);
                end
            end
            ST_FACT_TEST:
            begin
                rem_next = '0;
                quo_next = cur_i;
                cnt_next = '0;
            end
            ST_DIV:
            begin
                if (rem_sh >= {1'b0, j_reg})
                begin
                    rem_next = rem_sub[IW-1:0];
                    quo_next = {quo_reg[IW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[IW-1:0];
                    quo_next = {quo_reg[IW-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
            end
            ST_FACT_READ:
            begin
                rd_b_addr = quo_reg;
                pend_next = (rem_reg == '0);
                j_next    = j_reg + 1'b1;
                jsq_next  = jsq_reg + SQW'({j_reg, 1'b1});
            end
            ST_WRITE:
            begin
                wr_en     = 1'b1;
                fill_next = fill_reg + 1'b1;
            end
            ST_LOOKUP:
            begin
                rd_a_addr = n_reg;
            end
            ST_LOOKUP_WAIT:
            begin
                res_count_next = rd_a_reg;
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = res_count_reg;
                    out_oor_next   = res_oor_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            j_reg         <= '0;
            min_reg       <= COUNT_MAX;
            pend_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            j_reg         <= j_next;
            min_reg       <= min_next;
            pend_reg      <= pend_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        jsq_reg       <= jsq_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        res_count_reg <= res_count_next;
        res_oor_reg   <= res_oor_next;
        out_count_reg <= out_count_next;
        out_oor_reg   <= out_oor_next;
    end

endmodule
